>>> rtl/oversampled_state_variable_filter_defines.svh
// Assertion macros shared by the filter RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef OVERSAMPLED_STATE_VARIABLE_FILTER_DEFINES_SVH
`define OVERSAMPLED_STATE_VARIABLE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define OSVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define OSVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OSVF_ASSERT(lbl, prop, msg)
`define OSVF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/osvf_pkg.sv
// Shared types and constants of the oversampled state-variable filter.
// No dependencies; imported by every module of the block.
package osvf_pkg;

  localparam int OVERSAMPLE_DEF = 3;

  localparam int K_TUNE  = 34043;
  localparam int C_3     = 10923;
  localparam int C_5     = 546;
  localparam int C_7     = 13;
  localparam int Q16_ONE = 65536;

  localparam logic [16:0] MIN_CUTOFF_RST = 17'd27;

  localparam logic [2:0] MODE_BYPASS = 3'd0;
  localparam logic [2:0] MODE_LOW    = 3'd1;
  localparam logic [2:0] MODE_HIGH   = 3'd2;
  localparam logic [2:0] MODE_BAND   = 3'd3;
  localparam logic [2:0] MODE_NOTCH  = 3'd4;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RES        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CUTOFF = 4'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] cutoff_knob;
    logic [16:0] res_knob;
    logic [16:0] min_cutoff;
  } cfg_t;

  typedef struct packed {
    logic               bypass;
    logic signed [15:0] audio;
    logic [10:0]        cutoff_cv;
    logic [10:0]        res_cv;
  } item_t;

endpackage

>>> rtl/oversampled_state_variable_filter.sv
// Sequence: a bypass request goes from the pop straight to the output register; a
// filtered request passes the pop, the shared multiplier, averaging and the output.
// The engine takes one request at a time, held by the multiplier sequence and the
// reciprocal averaging step; the input FIFO and output register absorb stalls.
// Reset is synchronous: integrators clear, control and configuration registers return to their defaults.
// Depends on osvf_pkg, osvf_front, osvf_engine and osvf_avg.
module oversampled_state_variable_filter #(
  parameter int OVERSAMPLE = osvf_pkg::OVERSAMPLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic signed [15:0]             in_audio_in,
  input  logic [10:0]                    in_cutoff_cv,
  input  logic [10:0]                    in_res_cv,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [15:0]             out_audio_out,
  input  logic                           cfg_we,
  input  logic [osvf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [16:0]                    cfg_wdata
);
  import osvf_pkg::*;

  cfg_t               cfg_r;
  logic               item_valid, item_pop;
  item_t              item;
  logic               res_valid, res_ready;
  logic signed [15:0] res_data;
  logic               out_valid_r;
  logic signed [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_BYPASS;
      cfg_r.cutoff_knob <= '0;
      cfg_r.res_knob    <= '0;
      cfg_r.min_cutoff  <= MIN_CUTOFF_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:       cfg_r.mode        <= cfg_wdata[2:0];
        REG_CUTOFF:     cfg_r.cutoff_knob <= cfg_wdata[12:0];
        REG_RES:        cfg_r.res_knob    <= cfg_wdata;
        REG_MIN_CUTOFF: cfg_r.min_cutoff  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  osvf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .audio      (in_audio_in),
    .cutoff_cv  (in_cutoff_cv),
    .res_cv     (in_res_cv),
    .mode       (cfg_r.mode),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  osvf_engine #(.OVERSAMPLE(OVERSAMPLE)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_ready  (res_ready)
  );

  assign res_ready = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign empty         = !out_valid_r;
  assign out_audio_out = out_data_r;

endmodule

>>> rtl/osvf_front.sv
// Front end: takes requests, marks bypass requests and queues them in a two-entry FIFO.
// Depends on osvf_pkg.
module osvf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] audio,
  input  logic [10:0]        cutoff_cv,
  input  logic [10:0]        res_cv,
  input  logic [2:0]         mode,
  output logic               item_valid,
  output osvf_pkg::item_t    item,
  input  logic               item_pop
);
  import osvf_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;
  item_t      new_item;

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign wr         = push && !full;
  assign rd         = item_pop && item_valid;

  always_comb begin
    new_item.bypass    = !(mode inside {MODE_LOW, MODE_HIGH, MODE_BAND, MODE_NOTCH});
    new_item.audio     = audio;
    new_item.cutoff_cv = cutoff_cv;
    new_item.res_cv    = res_cv;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= new_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/osvf_avg.sv
// Averaging unit: divides the three pass sums by the oversampling factor with a reciprocal
// multiplication, upper chunk first, then selects and saturates the output. Depends on osvf_pkg.
`include "oversampled_state_variable_filter_defines.svh"
module osvf_avg #(
  parameter int OVERSAMPLE = osvf_pkg::OVERSAMPLE_DEF,
  localparam int SW = 33 + $clog2(OVERSAMPLE)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           mode,
  input  logic signed [SW-1:0] s_lp,
  input  logic signed [SW-1:0] s_hp,
  input  logic signed [SW-1:0] s_bp,
  output logic                 busy,
  output logic                 done,
  output logic signed [15:0]   y
);
  import osvf_pkg::*;

  localparam int DIVISOR = 2 * OVERSAMPLE;
  localparam int DW      = $clog2(DIVISOR + 1);
  localparam int UW      = SW + 2;
  localparam int WW      = UW + 3;
  localparam int LW      = 20;
  localparam int XW      = LW + 4;
  localparam int RK      = XW + 4;
  localparam int RECIP   = ((1 << RK) + DIVISOR - 1) / DIVISOR;
  localparam int NCY     = 2;
  localparam int CW      = $clog2(NCY + 1);

  logic [WW-1:0]        num_r [3];
  logic [UW-1:0]        quo_r [3];
  logic [DW-1:0]        rem_r [3];
  logic [XW-1:0]        div_x [3];
  logic [XW-1:0]        div_q [3];
  logic [DW-1:0]        div_r [3];
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic signed [UW-1:0] q_lp, q_hp, q_bp;

  function automatic logic [WW-1:0] dividend(input logic signed [SW-1:0] s);
    logic signed [UW-1:0] u;
    u = {s[SW-1], s, 1'b0} + UW'(OVERSAMPLE);
    return WW'(u) + (WW'(DIVISOR) << (UW - 1));
  endfunction

  function automatic logic [XW-1:0] recip_div(input logic [XW-1:0] x);
    logic [XW+RK-1:0] p;
    p = (XW+RK)'(x) * (XW+RK)'(RECIP);
    return p[XW+RK-1:RK];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [UW:0] v);
    if (v > (UW+1)'(32767)) begin
      return 16'sh7FFF;
    end else if (v < (UW+1)'(-32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // The upper chunk is divided first, then the remainder joined with
  // the lower 20 bits.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (cnt_r == CW'(NCY)) begin
        div_x[l] = XW'(num_r[l][WW-1:LW]);
      end else begin
        div_x[l] = XW'({rem_r[l], num_r[l][LW-1:0]});
      end
      div_q[l] = recip_div(div_x[l]);
      div_r[l] = DW'(div_x[l] - div_q[l] * XW'(DIVISOR));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r[0] <= dividend(s_lp);
      num_r[1] <= dividend(s_hp);
      num_r[2] <= dividend(s_bp);
    end else if (busy_r) begin
      for (int l = 0; l < 3; l++) begin
        if (cnt_r == CW'(NCY)) begin
          quo_r[l][UW-1:LW] <= div_q[l][UW-LW-1:0];
          rem_r[l]          <= div_r[l];
        end else begin
          quo_r[l][LW-1:0] <= div_q[l][LW-1:0];
        end
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NCY);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q_lp = {~quo_r[0][UW-1], quo_r[0][UW-2:0]};
  assign q_hp = {~quo_r[1][UW-1], quo_r[1][UW-2:0]};
  assign q_bp = {~quo_r[2][UW-1], quo_r[2][UW-2:0]};

  always_comb begin
    case (mode)
      MODE_LOW:  y = sat16((UW+1)'(q_lp));
      MODE_HIGH: y = sat16((UW+1)'(q_hp));
      MODE_BAND: y = sat16((UW+1)'(q_bp));
      default:   y = sat16((UW+1)'(q_lp) + (UW+1)'(q_hp));
    endcase
  end

  assign busy = busy_r;
  assign done = done_r;

  `OSVF_ASSERT(a_no_restart, start |-> !busy_r, "averaging restarted while busy")
  `OSVF_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held longer than one cycle")
  `OSVF_ASSERT(a_done_idle, done_r |-> !busy_r, "done raised while still dividing")

endmodule

>>> rtl/osvf_engine.sv
// Back end: sequencer around one shared multiplier that derives the coefficients
// and runs the filter passes, then hands the sums to osvf_avg. Depends on osvf_pkg.
`include "oversampled_state_variable_filter_defines.svh"
module osvf_engine #(
  parameter int OVERSAMPLE = osvf_pkg::OVERSAMPLE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  osvf_pkg::cfg_t     cfg,
  input  logic               item_valid,
  input  osvf_pkg::item_t    item,
  output logic               item_pop,
  output logic               res_valid,
  output logic signed [15:0] res_data,
  input  logic               res_ready
);
  import osvf_pkg::*;

  localparam int SW  = 33 + $clog2(OVERSAMPLE);
  localparam int PCW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_WB   = 6'b000100,
    ST_AVG  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    SP_CUT, SP_FX, SP_FX2, SP_FX3, SP_FX5, SP_FX7,
    SP_T3, SP_T5, SP_T7, SP_RES, SP_LPM, SP_DM, SP_HPM
  } step_t;

  state_t  state_r, state_nxt;
  step_t   step_r, step_nxt;
  logic [PCW-1:0] pass_r, pass_nxt;

  logic signed [15:0] x_r, y_r;
  logic [10:0]        ccv_r, rcv_r;
  logic signed [50:0] prod_r, mul_p, rnd;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] q;
  logic [16:0]        cut_r, fx_r, fx2_r, fx3_r, fx5_r, fx7_r, damp_r;
  logic signed [18:0] acc_r, poly;
  logic signed [19:0] ptwo;
  logic [15:0]        f_r, f_c;
  logic [23:0]        pc, c1;
  logic [16:0]        cut_c, damp_c;
  logic [18:0]        rp;
  logic signed [31:0] lp_r, bp_r, hp_r, lp_c, hp_c, bp_c;
  logic signed [SW-1:0] slp_r, shp_r, sbp_r;
  logic               avg_start, avg_busy, avg_done;
  logic signed [15:0] avg_y;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      SP_CUT: begin mul_a = {20'd0, cfg.cutoff_knob}; mul_b = {7'd0, ccv_r}; end
      SP_FX:  begin mul_a = {16'd0, cut_r}; mul_b = 18'(K_TUNE); end
      SP_FX2: begin mul_a = {16'd0, fx_r};  mul_b = {1'b0, fx_r}; end
      SP_FX3: begin mul_a = {16'd0, fx2_r}; mul_b = {1'b0, fx_r}; end
      SP_FX5: begin mul_a = {16'd0, fx3_r}; mul_b = {1'b0, fx2_r}; end
      SP_FX7: begin mul_a = {16'd0, fx5_r}; mul_b = {1'b0, fx2_r}; end
      SP_T3:  begin mul_a = {16'd0, fx3_r}; mul_b = 18'(C_3); end
      SP_T5:  begin mul_a = {16'd0, fx5_r}; mul_b = 18'(C_5); end
      SP_T7:  begin mul_a = {16'd0, fx7_r}; mul_b = 18'(C_7); end
      SP_RES: begin mul_a = {16'd0, cfg.res_knob}; mul_b = {7'd0, rcv_r}; end
      SP_LPM: begin mul_a = {bp_r[31], bp_r}; mul_b = {2'd0, f_r}; end
      SP_DM:  begin mul_a = {bp_r[31], bp_r}; mul_b = {1'b0, damp_r}; end
      SP_HPM: begin mul_a = {hp_r[31], hp_r}; mul_b = {2'd0, f_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign rnd   = prod_r + 51'sd32768;
  assign q     = rnd[50:16];

  always_comb begin
    pc    = prod_r[33:10];
    c1    = (pc < {7'd0, cfg.min_cutoff}) ? {7'd0, cfg.min_cutoff} : pc;
    cut_c = (c1 > 24'(Q16_ONE)) ? 17'(Q16_ONE) : c1[16:0];
    rp     = prod_r[28:10];
    damp_c = (rp > 19'(Q16_ONE)) ? 17'd0 : 17'(19'(Q16_ONE) - rp);
    poly = acc_r - q[18:0];
    ptwo = {poly, 1'b0};
    if (ptwo < 20'sd0) begin
      f_c = 16'd0;
    end else if (ptwo > 20'sd65535) begin
      f_c = 16'hFFFF;
    end else begin
      f_c = ptwo[15:0];
    end
    lp_c = sat32(36'(lp_r) + 36'(q));
    hp_c = sat32(36'(x_r) - 36'(lp_r) - 36'(q));
    bp_c = sat32(36'(bp_r) + 36'(q));
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pass_nxt  = pass_r;
    item_pop  = 1'b0;
    avg_start = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop  = 1'b1;
          step_nxt  = SP_CUT;
          pass_nxt  = '0;
          state_nxt = item.bypass ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_WB;
      ST_WB: begin
        state_nxt = ST_MUL;
        if (step_r == SP_HPM) begin
          if (pass_r == PCW'(OVERSAMPLE - 1)) begin
            state_nxt = ST_AVG;
          end else begin
            pass_nxt = pass_r + 1'b1;
            step_nxt = SP_LPM;
          end
        end else begin
          step_nxt = step_t'(step_r + 4'd1);
        end
      end
      ST_AVG: begin
        avg_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (avg_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r   <= item.audio;
        y_r   <= item.audio;
        ccv_r <= item.cutoff_cv;
        rcv_r <= item.res_cv;
        slp_r <= '0;
        shp_r <= '0;
        sbp_r <= '0;
      end
      ST_MUL: prod_r <= mul_p;
      ST_DIV: y_r <= avg_y;
      default: ;
    endcase
    if (state_r == ST_WB) begin
      case (step_r)
        SP_CUT: cut_r <= cut_c;
        SP_FX:  fx_r  <= q[16:0];
        SP_FX2: fx2_r <= q[16:0];
        SP_FX3: fx3_r <= q[16:0];
        SP_FX5: fx5_r <= q[16:0];
        SP_FX7: fx7_r <= q[16:0];
        SP_T3:  acc_r <= {2'b0, fx_r} - q[18:0];
        SP_T5:  acc_r <= acc_r + q[18:0];
        SP_T7:  f_r   <= f_c;
        SP_RES: damp_r <= damp_c;
        SP_DM:  hp_r  <= hp_c;
        default: ;
      endcase
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= SP_CUT;
      pass_r  <= '0;
      lp_r    <= '0;
      bp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pass_r  <= pass_nxt;
      if (state_r == ST_WB && step_r == SP_LPM) begin
        lp_r <= lp_c;
      end
      if (state_r == ST_WB && step_r == SP_HPM) begin
        bp_r  <= bp_c;
        slp_r <= slp_r + SW'(lp_r);
        shp_r <= shp_r + SW'(hp_r);
        sbp_r <= sbp_r + SW'(bp_c);
      end
    end
  end

  osvf_avg #(.OVERSAMPLE(OVERSAMPLE)) u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (avg_start),
    .mode  (cfg.mode),
    .s_lp  (slp_r),
    .s_hp  (shp_r),
    .s_bp  (sbp_r),
    .busy  (avg_busy),
    .done  (avg_done),
    .y     (avg_y)
  );

  assign res_data = y_r;

  `OSVF_ASSERT(a_avg_free, avg_start |-> !avg_busy, "averaging unit busy at start")
  `OSVF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")
  `OSVF_ASSERT_NEXT(a_bypass_state, state_r == ST_IDLE && item_valid && item.bypass, $stable(lp_r) && $stable(bp_r), "bypass request touched the integrators")

endmodule
